// ===== src/efrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efrd_pkg
// Shared types and constants of the earliest free room dispatcher: the item
// formats of both channels, the scan record that runs along the room cells,
// the write command that the controller broadcasts and the controller states.
// ----------------------------------------------------------------------------
package efrd_pkg;

    // Field widths.
    localparam int TIME_W    = 48;
    localparam int IN_TIME_W = 32;
    localparam int USES_W    = 32;
    localparam int ROOM_W    = 4;
    localparam int RC_W      = 5;

    // Saturation limits.
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [USES_W-1:0] USES_MAX = {USES_W{1'b1}};

    // Reset value of the room count register.
    localparam logic [RC_W-1:0] ROOM_COUNT_RESET = 5'd16;

    // Command codes.
    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_JOB   = 1'b1;

    // Register indexes of the configuration port.
    localparam logic REG_ROOM_COUNT = 1'b0;

    // One input item.
    typedef struct packed {
        logic                 command;
        logic [IN_TIME_W-1:0] start_time;
        logic [IN_TIME_W-1:0] end_time;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [ROOM_W-1:0] assigned_room;
        logic [TIME_W-1:0] actual_start;
        logic [TIME_W-1:0] actual_finish;
        logic              was_delayed;
        logic [ROOM_W-1:0] busiest_room;
        logic [USES_W-1:0] busiest_count;
        logic              bad_item;
    } out_item_t;

    // Scan record handed from cell to cell; the room indexes travel beside it.
    typedef struct packed {
        logic              valid;
        logic              free_found;
        logic [USES_W-1:0] free_uses;
        logic              min_valid;
        logic [TIME_W-1:0] min_finish;
        logic [USES_W-1:0] min_uses;
    } probe_t;

    // Write command broadcast to every cell; the target index travels beside it.
    typedef struct packed {
        logic              clear;
        logic              en;
        logic [TIME_W-1:0] finish;
        logic [USES_W-1:0] uses;
    } cell_wr_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE
    } ctrl_state_t;

endpackage

// ===== src/earliest_free_room_dispatcher_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_free_room_dispatcher_unit
// Places jobs on the lowest-numbered free room, or else on the room that
// finishes first, and reports the placement and the most-used room so far.
// ----------------------------------------------------------------------------
// A job item is captured at acceptance; its scan record then walks the row of
// ROOMS room cells, one cell a cycle, and the placement is registered from it.
// A clear or a bad item skips the scan. One item is in work at a time, so the
// next item is accepted only once the last result enters the output register.
// Reset (aresetn low, synchronous) empties all rooms and the busiest tracker
// and sets room_count to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module earliest_free_room_dispatcher_unit #(
    parameter int ROOMS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Input channel.
    input  logic                s_valid,
    output logic                s_ready,
    input  efrd_pkg::in_item_t  s_data,
    // Result channel.
    output logic                m_valid,
    input  logic                m_ready,
    output efrd_pkg::out_item_t m_data
);
    import efrd_pkg::*;

    localparam int IDX_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;
    localparam int CNT_W = $clog2(ROOMS + 1);
    localparam int CW    = (CNT_W > RC_W) ? CNT_W : RC_W;

    ctrl_state_t          state_reg;
    ctrl_state_t          state_next;
    logic [RC_W-1:0]      room_count_reg;
    logic                 cmd_reg;
    logic                 bad_reg;
    logic [IN_TIME_W-1:0] st_reg;
    logic [IN_TIME_W-1:0] en_reg;
    logic                 launch_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [TIME_W-1:0]    a_start_reg;
    logic [TIME_W-1:0]    a_finish_reg;
    logic                 delayed_reg;
    logic [USES_W-1:0]    new_uses_reg;
    logic [IDX_W-1:0]     best_room_reg;
    logic [IDX_W-1:0]     best_room_next;
    logic [USES_W-1:0]    best_uses_reg;
    logic [USES_W-1:0]    best_uses_next;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;
    out_item_t            m_data_next;

    logic                 s_accept;
    logic                 out_free;
    logic                 scan_done;
    logic                 do_write;
    logic [CW-1:0]        rc_ext;
    logic [CW-1:0]        n_active;
    logic [ROOMS-1:0]     active;
    cell_wr_t             wr;

    probe_t               chain_probe    [ROOMS+1];
    logic [IDX_W-1:0]     chain_free_idx [ROOMS+1];
    logic [IDX_W-1:0]     chain_min_idx  [ROOMS+1];

    logic [IN_TIME_W-1:0] dur;
    logic [TIME_W:0]      delay_sum;
    logic [IDX_W-1:0]     pick_c;
    logic [TIME_W-1:0]    a_start_c;
    logic [TIME_W-1:0]    a_finish_c;
    logic [USES_W-1:0]    old_uses_c;
    logic                 take_best;

    // Configuration port: one register, decoded on the index bit alone.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROOM_COUNT) ? {{(32-RC_W){1'b0}}, room_count_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            room_count_reg <= ROOM_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ROOM_COUNT)) begin
            room_count_reg <= pwdata[RC_W-1:0];
        end
    end

    // Active room count: zero counts as one, anything above ROOMS as ROOMS.
    assign rc_ext = CW'(room_count_reg);
    always_comb begin
        if (rc_ext == '0) begin
            n_active = CW'(1);
        end else if (rc_ext > CW'(ROOMS)) begin
            n_active = CW'(ROOMS);
        end else begin
            n_active = rc_ext;
        end
    end

    // Handshake helpers.
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_done = chain_probe[ROOMS].valid;
    assign do_write  = (state_reg == S_WRITE) && out_free;

    // Controller state register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Controller next state and handshake outputs.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if ((s_data.command == CMD_JOB) &&
                        (s_data.end_time >= s_data.start_time)) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Item capture and scan launch.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            launch_reg <= 1'b0;
        end else begin
            launch_reg <= s_accept && (s_data.command == CMD_JOB) &&
                          (s_data.end_time >= s_data.start_time);
        end
        if (s_accept) begin
            cmd_reg <= s_data.command;
            bad_reg <= (s_data.command == CMD_JOB) && (s_data.end_time < s_data.start_time);
            st_reg  <= s_data.start_time;
            en_reg  <= s_data.end_time;
        end
    end

    // The scan record enters the row with no candidate yet.
    always_comb begin
        chain_probe[0]       = '0;
        chain_probe[0].valid = launch_reg;
        chain_free_idx[0]    = '0;
        chain_min_idx[0]     = '0;
    end

    // Row of room cells.
    for (genvar i = 0; i < ROOMS; i++) begin : g_cell
        assign active[i] = (CW'(i) < n_active);

        efrd_cell #(
            .IDX_W (IDX_W)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .my_idx       (IDX_W'(i)),
            .active       (active[i]),
            .start_time   (st_reg),
            .probe_in     (chain_probe[i]),
            .free_idx_in  (chain_free_idx[i]),
            .min_idx_in   (chain_min_idx[i]),
            .probe_out    (chain_probe[i+1]),
            .free_idx_out (chain_free_idx[i+1]),
            .min_idx_out  (chain_min_idx[i+1]),
            .wr           (wr),
            .wr_idx       (pick_reg)
        );
    end

    // Placement from the finished scan: first free room, else earliest finish
    // with the requested duration kept and the finish saturating.
    assign dur       = en_reg - st_reg;
    assign delay_sum = {1'b0, chain_probe[ROOMS].min_finish} +
                       {{(TIME_W+1-IN_TIME_W){1'b0}}, dur};

    always_comb begin
        if (chain_probe[ROOMS].free_found) begin
            pick_c     = chain_free_idx[ROOMS];
            a_start_c  = {{(TIME_W-IN_TIME_W){1'b0}}, st_reg};
            a_finish_c = {{(TIME_W-IN_TIME_W){1'b0}}, en_reg};
            old_uses_c = chain_probe[ROOMS].free_uses;
        end else begin
            pick_c     = chain_min_idx[ROOMS];
            a_start_c  = chain_probe[ROOMS].min_finish;
            a_finish_c = delay_sum[TIME_W] ? TIME_MAX : delay_sum[TIME_W-1:0];
            old_uses_c = chain_probe[ROOMS].min_uses;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_SCAN) && scan_done) begin
            pick_reg     <= pick_c;
            a_start_reg  <= a_start_c;
            a_finish_reg <= a_finish_c;
            delayed_reg  <= !chain_probe[ROOMS].free_found;
            new_uses_reg <= (old_uses_c == USES_MAX) ? old_uses_c : old_uses_c + 1'b1;
        end
    end

    // Write command to the cells, issued once when the result is loaded.
    always_comb begin
        wr.clear  = do_write && (cmd_reg == CMD_CLEAR);
        wr.en     = do_write && (cmd_reg == CMD_JOB) && !bad_reg;
        wr.finish = a_finish_reg;
        wr.uses   = new_uses_reg;
    end

    // Busiest room tracker and the result item.
    assign take_best = (new_uses_reg > best_uses_reg) ||
                       ((new_uses_reg == best_uses_reg) && (pick_reg < best_room_reg));

    always_comb begin
        best_room_next = best_room_reg;
        best_uses_next = best_uses_reg;
        m_data_next    = '0;
        if (cmd_reg == CMD_CLEAR) begin
            best_room_next = '0;
            best_uses_next = '0;
        end else if (bad_reg) begin
            m_data_next.bad_item = 1'b1;
        end else begin
            if (take_best) begin
                best_room_next = pick_reg;
                best_uses_next = new_uses_reg;
            end
            m_data_next.assigned_room = ROOM_W'(pick_reg);
            m_data_next.actual_start  = a_start_reg;
            m_data_next.actual_finish = a_finish_reg;
            m_data_next.was_delayed   = delayed_reg;
            m_data_next.busiest_room  = ROOM_W'(best_room_next);
            m_data_next.busiest_count = best_uses_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_room_reg <= '0;
            best_uses_reg <= '0;
        end else if (do_write) begin
            best_room_reg <= best_room_next;
            best_uses_reg <= best_uses_next;
        end
    end

    // Output register: holds the result item until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_write) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (do_write) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/efrd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efrd_cell
// One room of the dispatcher. It holds the room's finish time and use count,
// folds itself into the scan record as that record passes, and takes the
// broadcast write or clear addressed to it.
// ----------------------------------------------------------------------------
module efrd_cell #(
    parameter int IDX_W = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [IDX_W-1:0]               my_idx,
    input  logic                           active,
    input  logic [efrd_pkg::IN_TIME_W-1:0] start_time,
    input  efrd_pkg::probe_t               probe_in,
    input  logic [IDX_W-1:0]               free_idx_in,
    input  logic [IDX_W-1:0]               min_idx_in,
    output efrd_pkg::probe_t               probe_out,
    output logic [IDX_W-1:0]               free_idx_out,
    output logic [IDX_W-1:0]               min_idx_out,
    input  efrd_pkg::cell_wr_t             wr,
    input  logic [IDX_W-1:0]               wr_idx
);
    import efrd_pkg::*;

    logic [TIME_W-1:0] finish_reg;
    logic [USES_W-1:0] uses_reg;
    probe_t            probe_reg;
    probe_t            probe_next;
    logic [IDX_W-1:0]  free_idx_reg;
    logic [IDX_W-1:0]  free_idx_next;
    logic [IDX_W-1:0]  min_idx_reg;
    logic [IDX_W-1:0]  min_idx_next;
    logic              take_free;
    logic              take_min;

    // This room is free if it finishes at or before the requested start.
    assign take_free = active && !probe_in.free_found &&
                       (finish_reg <= {{(TIME_W-IN_TIME_W){1'b0}}, start_time});
    // Strictly earlier finish wins, so the lowest index keeps ties.
    assign take_min  = active && (!probe_in.min_valid ||
                       (finish_reg < probe_in.min_finish));

    // Fold this room into the passing record.
    always_comb begin
        probe_next    = probe_in;
        free_idx_next = free_idx_in;
        min_idx_next  = min_idx_in;
        if (take_free) begin
            probe_next.free_found = 1'b1;
            probe_next.free_uses  = uses_reg;
            free_idx_next         = my_idx;
        end
        if (take_min) begin
            probe_next.min_valid  = 1'b1;
            probe_next.min_finish = finish_reg;
            probe_next.min_uses   = uses_reg;
            min_idx_next          = my_idx;
        end
    end

    // Room state: cleared by the clear command, written when addressed.
    always_ff @(posedge aclk) begin
        if (!aresetn || wr.clear) begin
            finish_reg <= '0;
            uses_reg   <= '0;
        end else if (wr.en && (wr_idx == my_idx)) begin
            finish_reg <= wr.finish;
            uses_reg   <= wr.uses;
        end
    end

    // Record stage towards the next cell; only the valid bit needs a reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg.valid <= 1'b0;
        end else begin
            probe_reg.valid <= probe_next.valid;
        end
        probe_reg.free_found <= probe_next.free_found;
        probe_reg.free_uses  <= probe_next.free_uses;
        probe_reg.min_valid  <= probe_next.min_valid;
        probe_reg.min_finish <= probe_next.min_finish;
        probe_reg.min_uses   <= probe_next.min_uses;
        free_idx_reg         <= free_idx_next;
        min_idx_reg          <= min_idx_next;
    end

    assign probe_out    = probe_reg;
    assign free_idx_out = free_idx_reg;
    assign min_idx_out  = min_idx_reg;

endmodule

// ===== tb/earliest_free_room_dispatcher_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_free_room_dispatcher_unit_tb
// Drives job, clear and malformed items through the dispatcher over many
// room count settings. A scoreboard model placing each accepted item keeps
// its own room finish times, use counts and busiest tracker. Every result is
// compared field by field, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module earliest_free_room_dispatcher_unit_tb;

    import efrd_pkg::*;

    localparam int NUM_ROOMS   = 16;
    localparam int JOB_LATENCY = NUM_ROOMS + 3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 140;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    // Scoreboard copy of the block state and its room count register.
    logic [TIME_W-1:0] room_free_at [NUM_ROOMS];
    logic [USES_W-1:0] room_jobs    [NUM_ROOMS];
    logic [ROOM_W-1:0] top_room;
    logic [USES_W-1:0] top_jobs;
    logic [RC_W-1:0]   room_count_cfg;

    in_item_t  jobs_to_send [$];
    out_item_t placements_due [$];

    int          errors      = 0;
    int          send_gap    = 0;
    int          sink_stall  = 0;
    int          hold_left   = 0;
    int          hold_token  = 0;
    int          hold_seen   = 0;
    bit          quiet       = 1'b0;
    int unsigned cycle_count = 0;
    int          jobs_placed = 0;
    int          jobs_late   = 0;
    int          bad_seen    = 0;
    int          clears_seen = 0;
    int          cfg_writes  = 0;

    earliest_free_room_dispatcher_unit #(
        .ROOMS(NUM_ROOMS)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #2 aclk = ~aclk;

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d items queued and %0d results outstanding",
                     $time, jobs_to_send.size(), placements_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Empties every room and the busiest tracker.
    function automatic void clear_rooms();
        for (int i = 0; i < NUM_ROOMS; i++) begin
            room_free_at[i] = '0;
            room_jobs[i]    = '0;
        end
        top_room = '0;
        top_jobs = '0;
    endfunction

    // Places one accepted item against the scoreboard state and returns
    // the result the block must produce for it.
    function automatic out_item_t place_job(in_item_t it);
        out_item_t         r;
        int unsigned       n;
        int unsigned       pick;
        bit                found;
        logic [TIME_W-1:0] req_start;
        logic [TIME_W-1:0] req_end;
        logic [TIME_W-1:0] span;
        r         = '0;
        n         = 32'(room_count_cfg);
        found     = 1'b0;
        pick      = 0;
        req_start = {16'd0, it.start_time};
        req_end   = {16'd0, it.end_time};
        span      = req_end - req_start;
        if (n < 1) begin
            n = 1;
        end
        if (n > NUM_ROOMS) begin
            n = NUM_ROOMS;
        end
        if (it.command == CMD_CLEAR) begin
            clear_rooms();
            return r;
        end
        if (it.end_time < it.start_time) begin
            r.bad_item = 1'b1;
            return r;
        end
        // Lowest-numbered active room that is already free.
        for (int unsigned i = 0; i < n; i++) begin
            if (!found && room_free_at[i] <= req_start) begin
                pick  = i;
                found = 1'b1;
            end
        end
        if (found) begin
            r.actual_start  = req_start;
            r.actual_finish = req_end;
        end else begin
            // All busy: earliest finisher, lowest index on ties, job slips.
            for (int unsigned i = 1; i < n; i++) begin
                if (room_free_at[i] < room_free_at[pick]) begin
                    pick = i;
                end
            end
            r.was_delayed  = 1'b1;
            r.actual_start = room_free_at[pick];
            if (span > TIME_MAX - room_free_at[pick]) begin
                r.actual_finish = TIME_MAX;
            end else begin
                r.actual_finish = room_free_at[pick] + span;
            end
        end
        room_free_at[pick] = r.actual_finish;
        if (room_jobs[pick] != USES_MAX) begin
            room_jobs[pick] = room_jobs[pick] + 1'b1;
        end
        if (room_jobs[pick] > top_jobs ||
            (room_jobs[pick] == top_jobs && pick < top_room)) begin
            top_jobs = room_jobs[pick];
            top_room = pick[ROOM_W-1:0];
        end
        r.assigned_room = pick[ROOM_W-1:0];
        r.busiest_room  = top_room;
        r.busiest_count = top_jobs;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic void add_item(logic cmd, logic [31:0] st, logic [31:0] en);
        in_item_t it;
        it.command    = cmd;
        it.start_time = st;
        it.end_time   = en;
        jobs_to_send.push_back(it);
    endfunction

    // Sender: offers queued items, with random gaps between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                placements_due.push_back(place_job(s_data));
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (jobs_to_send.size() > 0) begin
                    if (!quiet && $urandom_range(0, 99) < 12) begin
                        send_gap = $urandom_range(1, 10) - 1;
                        s_valid <= 1'b0;
                    end else begin
                        s_data  <= jobs_to_send.pop_front();
                        s_valid <= 1'b1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when asked for.
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 12) begin
            sink_stall = $urandom_range(1, 10) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker against the oldest outstanding placement.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (placements_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
                errors++;
            end else begin
                want = placements_due.pop_front();
                check_field("assigned_room", 64'(want.assigned_room),
                            64'(m_data.assigned_room));
                check_field("actual_start",  64'(want.actual_start),
                            64'(m_data.actual_start));
                check_field("actual_finish", 64'(want.actual_finish),
                            64'(m_data.actual_finish));
                check_field("was_delayed",   64'(want.was_delayed),
                            64'(m_data.was_delayed));
                check_field("busiest_room",  64'(want.busiest_room),
                            64'(m_data.busiest_room));
                check_field("busiest_count", 64'(want.busiest_count),
                            64'(m_data.busiest_count));
                check_field("bad_item",      64'(want.bad_item),
                            64'(m_data.bad_item));
                if (want.bad_item) begin
                    bad_seen++;
                end else if (want == '0) begin
                    clears_seen++;
                end else begin
                    jobs_placed++;
                    if (want.was_delayed) begin
                        jobs_late++;
                    end
                end
            end
        end
    end

    // Waits until every item is sent and every result has come back.
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (jobs_to_send.size() != 0 || s_valid || placements_due.size() != 0);
    endtask

    // Register write of the room count, upper bits random.
    task automatic write_room_count(logic [RC_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ROOM_COUNT, 2'b00};
        pwdata  <= {27'($urandom_range(0, 32'h07FF_FFFF)), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        room_count_cfg = value;
        cfg_writes++;
    endtask

    // Mostly ordered job streams that keep the rooms contended, with some
    // clears, malformed jobs and fully random items mixed in.
    task automatic queue_random_phase(int count);
        int unsigned eff;
        int unsigned step_max;
        int unsigned dur_max;
        int unsigned roll;
        logic [31:0] cursor;
        logic [32:0] stop;
        logic [31:0] st;
        eff      = (room_count_cfg == 0) ? 1 :
                   (room_count_cfg > NUM_ROOMS) ? NUM_ROOMS : 32'(room_count_cfg);
        step_max = $urandom_range(0, 20);
        dur_max  = (step_max + 1) * eff * $urandom_range(1, 3);
        cursor   = $urandom_range(0, 1) ? 32'd0 : $urandom;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                add_item(CMD_CLEAR, $urandom, $urandom);
            end else if (roll < 9) begin
                st = $urandom_range(1, 32'hFFFF_FFFF);
                add_item(CMD_JOB, st, $urandom_range(0, st - 1));
            end else if (roll < 14) begin
                add_item(CMD_JOB, $urandom, $urandom);
            end else begin
                cursor = cursor + $urandom_range(0, step_max);
                stop   = {1'b0, cursor} + $urandom_range(0, dur_max);
                add_item(CMD_JOB, cursor, stop[32] ? 32'hFFFF_FFFF : stop[31:0]);
            end
        end
    endtask

    initial begin
        logic [RC_W-1:0] cfg_plan [PHASES];
        cfg_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd9, 5'd3, 5'd8, 5'd16};
        cfg_plan[6] = RC_W'($urandom_range(2, 15));
        room_count_cfg = ROOM_COUNT_RESET;
        clear_rooms();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset setting: field extremes, malformed jobs, out-of-order start.
        add_item(CMD_JOB,   32'd0,          32'd0);
        add_item(CMD_JOB,   32'd0,          32'hFFFF_FFFF);
        add_item(CMD_JOB,   32'hFFFF_FFFF,  32'hFFFF_FFFF);
        add_item(CMD_JOB,   32'd5,          32'd4);
        add_item(CMD_JOB,   32'hFFFF_FFFF,  32'd0);
        add_item(CMD_JOB,   32'd3,          32'd7);
        add_item(CMD_CLEAR, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
        add_item(CMD_JOB,   32'd0,          32'd0);
        add_item(CMD_CLEAR, 32'd0,          32'd0);
        wait_idle();

        // Two rooms: finish-time ties and busiest-room ties.
        write_room_count(5'd2);
        add_item(CMD_JOB,   32'd0,  32'd10);
        add_item(CMD_JOB,   32'd0,  32'd10);
        add_item(CMD_JOB,   32'd0,  32'd5);
        add_item(CMD_JOB,   32'd12, 32'd20);
        add_item(CMD_JOB,   32'd9,  32'd8);
        add_item(CMD_JOB,   32'd30, 32'd30);
        add_item(CMD_CLEAR, $urandom, $urandom);
        add_item(CMD_JOB,   32'd1,  32'd1);
        wait_idle();

        // Zero room count acts as one room: chained delays past 32 bits.
        write_room_count(5'd0);
        add_item(CMD_JOB, 32'd10,         32'd20);
        add_item(CMD_JOB, 32'd10,         32'd30);
        add_item(CMD_JOB, 32'd15,         32'd15);
        add_item(CMD_JOB, 32'd5,          32'd100);
        add_item(CMD_JOB, 32'hFFFF_FFF0,  32'hFFFF_FFFF);
        add_item(CMD_JOB, 32'hFFFF_FFF0,  32'hFFFF_FFFF);

        // Random phases, each under its own room count setting.
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            if (ph == PHASES - 1) begin
                quiet = 1'b1;
            end
            write_room_count(cfg_plan[ph]);
            if ($urandom_range(0, 1)) begin
                add_item(CMD_CLEAR, $urandom, $urandom);
            end
            if (ph == 2) begin
                hold_token++;
            end
            queue_random_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (2 * JOB_LATENCY) @(posedge aclk);
        $display("Covered %0d placed jobs (%0d delayed), %0d malformed jobs, %0d clears,",
                 jobs_placed, jobs_late, bad_seen, clears_seen);
        $display("under %0d room count settings, with %0d mismatches.", cfg_writes, errors);
        if (errors == 0 && placements_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
